@@ design/lpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared constants and types for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int CMD_BYTES    = 2;
	localparam int POS_W        = $clog2(HEADER_BYTES);

	localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

	localparam logic [POS_W-1:0] POS_FIRST     = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CMD_LAST  = POS_W'(CMD_BYTES - 1);
	localparam logic [POS_W-1:0] POS_LEN_FIRST = POS_W'(CMD_BYTES);
	localparam logic [POS_W-1:0] POS_LAST      = POS_W'(HEADER_BYTES - 1);

	typedef logic [POS_W-1:0] hdr_pos_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic        is_payload;
		logic        message_end;
		logic        len_over_max;
		logic [15:0] command_code;
		logic [31:0] payload_length;
		logic [31:0] bytes_left;
	} result_t;

endpackage

@@ design/length_prefixed_message_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_unit
// Splits a byte stream into header and payload bytes and tags each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, stream_byte) carries one stream byte
//   per transfer. Output channel (out_valid, out_stall, result fields) returns
//   exactly one tagged result per input byte, in order.
//   Each message is a six-byte header (two command bytes, big-endian 32-bit
//   length) followed by the payload. A length above max_payload_length sets
//   len_over_max on the last header byte and the next byte starts a new header.
//   cfg_write_en / cfg_write_data write max_payload_length; write only while
//   the block is idle.
//   The result is held in the output register the cycle after the transfer.
//   Throughput: one byte per cycle when not stalled; the header position,
//   length and count registers update in the same cycle the byte is taken.
//   Reset: state clears, max_payload_length returns to 1048576, no result is
//   pending. While the receiver stalls a full output register, in_stall is
//   raised and the result holds; in the cycle the result is taken a new byte
//   may enter.
module length_prefixed_message_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  echo_byte,
	output logic        is_payload,
	output logic        message_end,
	output logic        len_over_max,
	output logic [15:0] command_code,
	output logic [31:0] payload_length,
	output logic [31:0] bytes_left
);
	import lpmd_pkg::*;

	logic [31:0] max_len_q;
	logic        in_payload_q;
	hdr_pos_t    hdr_pos_q;
	logic [15:0] cmd_q;
	logic [31:0] len_q;
	logic [31:0] rem_q;

	logic        in_payload_d;
	hdr_pos_t    hdr_pos_d;
	logic [15:0] cmd_d;
	logic [31:0] len_d;
	logic [31:0] rem_d;
	result_t     res_d;
	result_t     res_s1;
	logic        valid_s1;
	logic        take;

	assign in_stall = valid_s1 && out_stall;
	assign take     = in_valid && !in_stall;

	always_comb begin
		in_payload_d = in_payload_q;
		hdr_pos_d    = hdr_pos_q;
		cmd_d        = cmd_q;
		len_d        = len_q;
		rem_d        = rem_q;
		res_d        = '0;
		res_d.echo_byte = stream_byte;
		if (in_payload_q) begin
			rem_d                = rem_q - 32'd1;
			res_d.is_payload     = 1'b1;
			res_d.command_code   = cmd_q;
			res_d.payload_length = len_q;
			res_d.bytes_left     = rem_d;
			if (rem_d == 32'd0) begin
				res_d.message_end = 1'b1;
				in_payload_d      = 1'b0;
				hdr_pos_d         = POS_FIRST;
			end
		end else begin
			if (hdr_pos_q == POS_FIRST) begin
				cmd_d = {8'd0, stream_byte};
			end else if (hdr_pos_q <= POS_CMD_LAST) begin
				cmd_d = {cmd_q[7:0], stream_byte};
			end else if (hdr_pos_q == POS_LEN_FIRST) begin
				len_d = {24'd0, stream_byte};
			end else begin
				len_d = {len_q[23:0], stream_byte};
			end
			if (hdr_pos_q >= POS_LAST) begin
				res_d.command_code   = cmd_d;
				res_d.payload_length = len_d;
				hdr_pos_d            = POS_FIRST;
				if (len_d > max_len_q) begin
					res_d.len_over_max = 1'b1;
				end else if (len_d == 32'd0) begin
					res_d.message_end = 1'b1;
				end else begin
					rem_d            = len_d;
					res_d.bytes_left = len_d;
					in_payload_d     = 1'b1;
				end
			end else begin
				hdr_pos_d = hdr_pos_q + hdr_pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= MAX_LEN_RESET;
			in_payload_q <= 1'b0;
			hdr_pos_q    <= POS_FIRST;
			cmd_q        <= '0;
			len_q        <= '0;
			rem_q        <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				max_len_q <= cfg_write_data;
			end
			if (take) begin
				in_payload_q <= in_payload_d;
				hdr_pos_q    <= hdr_pos_d;
				cmd_q        <= cmd_d;
				len_q        <= len_d;
				rem_q        <= rem_d;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (!out_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res_d;
		end
	end

	assign out_valid      = valid_s1;
	assign echo_byte      = res_s1.echo_byte;
	assign is_payload     = res_s1.is_payload;
	assign message_end    = res_s1.message_end;
	assign len_over_max   = res_s1.len_over_max;
	assign command_code   = res_s1.command_code;
	assign payload_length = res_s1.payload_length;
	assign bytes_left     = res_s1.bytes_left;

`ifndef SYNTH
	a_payload_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (hdr_pos_q == POS_FIRST && rem_q != 32'd0))
		else $error("payload state with header position or empty count");

	a_last_payload_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_payload_q && rem_q == 32'd1) |=>
		(!in_payload_q && out_valid && message_end))
		else $error("last payload byte did not end the message");

	a_error_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && len_over_max) |->
		(bytes_left == 32'd0 && !message_end && !is_payload && !in_payload_q))
		else $error("length error with payload pending");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !take)
		else $error("input taken while result held");
`endif

endmodule
